@@ rtl/core/spc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spc_pkg: shared definitions for the 8.3 short-name path compare
// Character codes, input sizes, lane result type and byte selectors used by
// the lanes, the merge stage and the top level.
// ----------------------------------------------------------------------------
package spc_pkg;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam int PATH_HEAD_BYTES = 8;
  localparam int PATH_BYTES      = 13;
  localparam int BASE_BYTES      = 8;
  localparam int EXT_BYTES       = 3;

  localparam int PATH_HEAD_W = 8 * PATH_HEAD_BYTES;
  localparam int PATH_TAIL_W = 8 * (PATH_BYTES - PATH_HEAD_BYTES);
  localparam int NAME_BASE_W = 8 * BASE_BYTES;
  localparam int NAME_EXT_W  = 8 * EXT_BYTES;
  localparam int USED_OUT_W  = 4;

  localparam int BASE_LEN_DEF = 8;
  localparam int EXT_LEN_DEF  = 3;
  localparam int BASE_LEN_MAX = 16;
  localparam int EXT_LEN_MAX  = 8;

  // Wide enough for the largest count at the largest lengths.
  localparam int USED_MAX_W = $clog2(BASE_LEN_MAX + EXT_LEN_MAX + 3);

  typedef struct packed {
    logic                  eq;
    logic [USED_MAX_W-1:0] used;
  } spc_lane_t;

  function automatic logic is_term(input logic [7:0] c);
    return (c == CH_NUL) || (c == CH_SLASH) || (c == CH_BSLASH);
  endfunction

  function automatic logic [7:0] path_byte(input logic [PATH_HEAD_W-1:0] head,
                                           input logic [PATH_TAIL_W-1:0] tail,
                                           input int idx);
    logic [7:0] r;
    r = CH_NUL;
    if (idx < PATH_HEAD_BYTES) begin
      r = head[8*idx +: 8];
    end else if (idx < PATH_BYTES) begin
      r = tail[8*(idx-PATH_HEAD_BYTES) +: 8];
    end
    return r;
  endfunction

  function automatic logic [7:0] base_byte(input logic [NAME_BASE_W-1:0] base,
                                           input int idx);
    logic [7:0] r;
    r = CH_SPACE;
    if (idx < BASE_BYTES) begin
      r = base[8*idx +: 8];
    end
    return r;
  endfunction

  function automatic logic [7:0] ext_byte(input logic [NAME_EXT_W-1:0] ext,
                                          input int idx);
    logic [7:0] r;
    r = CH_SPACE;
    if (idx < EXT_BYTES) begin
      r = ext[8*idx +: 8];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/spc_lane.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spc_lane: one base-name position of the short-name compare
// Decides whether the path byte at this position matches the entry, and the
// byte count that results if the component first departs from the entry here.
// ----------------------------------------------------------------------------
module spc_lane #(
  parameter int POS      = 0,
  parameter int BASE_LEN = spc_pkg::BASE_LEN_DEF,
  parameter int EXT_LEN  = spc_pkg::EXT_LEN_DEF
) (
  input  wire logic [spc_pkg::PATH_HEAD_W-1:0] path_head,
  input  wire logic [spc_pkg::PATH_TAIL_W-1:0] path_tail,
  input  wire logic [spc_pkg::NAME_BASE_W-1:0] name_base,
  input  wire logic [spc_pkg::NAME_EXT_W-1:0]  name_ext,
  output spc_pkg::spc_lane_t                   res
);
  import spc_pkg::*;

  always_comb begin
    logic [7:0]            pc;
    logic [7:0]            pk;
    logic                  stop;
    logic                  base_blank;
    logic [EXT_LEN:0]      blank;
    logic [USED_MAX_W-1:0] ext_used;

    pc = path_byte(path_head, path_tail, POS);
    res.eq = 1'b0;
    if (POS < BASE_LEN) begin
      res.eq = (pc == base_byte(name_base, POS));
    end

    base_blank = 1'b1;
    for (int j = POS; j < BASE_LEN; j++) begin
      if (base_byte(name_base, j) != CH_SPACE) begin
        base_blank = 1'b0;
      end
    end

    blank[EXT_LEN] = 1'b1;
    for (int k = EXT_LEN - 1; k >= 0; k--) begin
      blank[k] = blank[k+1] && (ext_byte(name_ext, k) == CH_SPACE);
    end

    // The first extension position that stops the compare decides the count.
    ext_used = '0;
    for (int k = EXT_LEN; k >= 0; k--) begin
      pk   = path_byte(path_head, path_tail, POS + 1 + k);
      stop = (k == EXT_LEN) || (pk != ext_byte(name_ext, k));
      if (stop) begin
        ext_used = (is_term(pk) && blank[k]) ? USED_MAX_W'(POS + 2 + k) : '0;
      end
    end

    res.used = '0;
    if (base_blank) begin
      if (pc == CH_DOT) begin
        res.used = ext_used;
      end else if (is_term(pc) && blank[0]) begin
        res.used = USED_MAX_W'(POS + 1);
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/spc_merge.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spc_merge: merging stage of the short-name compare
// Picks the result of the first lane whose path byte departs from the entry.
// ----------------------------------------------------------------------------
module spc_merge #(
  parameter int BASE_LEN = spc_pkg::BASE_LEN_DEF
) (
  input  wire spc_pkg::spc_lane_t [BASE_LEN:0]  lanes,
  output logic                                  is_match,
  output logic [spc_pkg::USED_OUT_W-1:0]        bytes_used
);
  import spc_pkg::*;

  logic [USED_MAX_W-1:0] used;

  always_comb begin
    used = '0;
    for (int i = BASE_LEN; i >= 0; i--) begin
      if (!lanes[i].eq) begin
        used = lanes[i].used;
      end
    end
  end

  assign is_match   = (used != '0);
  assign bytes_used = used[USED_OUT_W-1:0];

endmodule
`default_nettype wire

@@ rtl/core/short_name_path_compare.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// short_name_path_compare: 8.3 short-name path component compare
// Compares the next component of a path with one space-padded directory
// entry name and reports the match and the number of path bytes used.
// ----------------------------------------------------------------------------
// Each input word carries up to thirteen path bytes and one entry name; each
// output word carries is_match and bytes_used for that entry. Both channels
// use valid and ready. One lane per base-name position checks its byte and
// works out the count that follows if the component departs from the entry
// there; the lane results are registered, and the merge stage picks the first
// departing lane into the output register.
// Throughput is one word per cycle while out_ready stays high, set by the
// two-register pipeline with no loop. A word is accepted while a finished
// result waits, as long as a pipeline register is free; when the receiver
// stalls, both registers fill and in_ready falls until out_ready returns.
// Reset empties the pipeline; no words are held over and no state is kept
// between words.
// ----------------------------------------------------------------------------
module short_name_path_compare #(
  parameter int BASE_LEN = spc_pkg::BASE_LEN_DEF,
  parameter int EXT_LEN  = spc_pkg::EXT_LEN_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [spc_pkg::PATH_HEAD_W-1:0]  path_head,
  input  wire logic [spc_pkg::PATH_TAIL_W-1:0]  path_tail,
  input  wire logic [spc_pkg::NAME_BASE_W-1:0]  name_base,
  input  wire logic [spc_pkg::NAME_EXT_W-1:0]   name_ext,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  is_match,
  output logic [spc_pkg::USED_OUT_W-1:0]        bytes_used
);
  import spc_pkg::*;

  spc_lane_t [BASE_LEN:0] lane_res;
  spc_lane_t [BASE_LEN:0] s1_lanes;
  logic                   s1_valid;
  logic                   s1_adv;
  logic                   out_free;
  logic                   merge_match;
  logic [USED_OUT_W-1:0]  merge_used;

  for (genvar i = 0; i <= BASE_LEN; i++) begin : g_lane
    spc_lane #(
      .POS      (i),
      .BASE_LEN (BASE_LEN),
      .EXT_LEN  (EXT_LEN)
    ) u_lane (
      .path_head (path_head),
      .path_tail (path_tail),
      .name_base (name_base),
      .name_ext  (name_ext),
      .res       (lane_res[i])
    );
  end

  spc_merge #(
    .BASE_LEN (BASE_LEN)
  ) u_merge (
    .lanes      (s1_lanes),
    .is_match   (merge_match),
    .bytes_used (merge_used)
  );

  assign out_free = !out_valid || out_ready;
  assign s1_adv   = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_lanes <= lane_res;
    end
    if (s1_adv) begin
      is_match   <= merge_match;
      bytes_used <= merge_used;
    end
  end

`ifndef SYNTHESIS
  a_nomatch_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_match |-> bytes_used == '0)
    else $error("A mismatch reports a non-zero byte count.");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> s1_valid)
    else $error("An accepted word did not reach the lane register.");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1_lanes))
    else $error("The lane register lost a word while the output was blocked.");

  a_advance_out: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> out_valid)
    else $error("A word left the lane register without reaching the output.");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !s1_valid |=> !out_valid)
    else $error("The output stayed valid after its word was taken.");
`endif

endmodule
`default_nettype wire

@@ test/tb_short_name_path_compare.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_short_name_path_compare: regression for the 8.3 short-name path compare
// The bench sends path components with directory entry names and works out
// the expected match and byte count for each one. The received results are
// checked against the expected ones in order. Directed cases come first.
// Random entries follow: well-formed names, names with one fault, and
// some random noise. Both sides idle at random, and one phase stalls the
// output for a long time.
// ----------------------------------------------------------------------------
module tb_short_name_path_compare;
  import spc_pkg::*;

  localparam int NAME_LEN    = BASE_LEN_DEF;
  localparam int EXTN_LEN    = EXT_LEN_DEF;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 250000;

  typedef struct {
    logic [103:0] path;
    logic [63:0]  base;
    logic [23:0]  ext;
    logic         hit;
    logic [3:0]   used;
  } compare_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [PATH_HEAD_W-1:0] path_head = '0;
  logic [PATH_TAIL_W-1:0] path_tail = '0;
  logic [NAME_BASE_W-1:0] name_base = '0;
  logic [NAME_EXT_W-1:0]  name_ext = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   is_match;
  logic [USED_OUT_W-1:0]  bytes_used;

  compare_t pending[$];
  compare_t want;
  bit       tx_idle = 1'b1;
  logic     rx_idle = 1'b1;
  int       rx_wait = 0;
  int       rx_stall;
  int       hold_requests = 0;
  int       hold_served = 0;
  int       cycles = 0;
  int       words_sent = 0;
  int       directed_words = 0;
  int       results_checked = 0;
  int       matches_seen = 0;
  int       errors = 0;

  short_name_path_compare dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .path_head  (path_head),
    .path_tail  (path_tail),
    .name_base  (name_base),
    .name_ext   (name_ext),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .is_match   (is_match),
    .bytes_used (bytes_used)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit is_separator(input logic [7:0] c);
    return (c == CH_NUL) || (c == CH_SLASH) || (c == CH_BSLASH);
  endfunction

  function automatic bit ext_spaces_from(input logic [23:0] ext, input int k);
    for (int n = k; n < EXTN_LEN; n++) begin
      if (ext[8*n +: 8] != CH_SPACE) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic int ext_bytes_used(input logic [103:0] path, input logic [23:0] ext,
                                        input int p);
    logic [7:0] c;
    for (int k = 0; k < EXTN_LEN; k++) begin
      c = path[8*(p+k) +: 8];
      if (c == ext[8*k +: 8]) begin
        continue;
      end
      if (is_separator(c)) begin
        return ext_spaces_from(ext, k) ? p + k + 1 : 0;
      end
      return 0;
    end
    c = path[8*(p+EXTN_LEN) +: 8];
    return is_separator(c) ? p + EXTN_LEN + 1 : 0;
  endfunction

  function automatic int entry_bytes_used(input logic [103:0] path, input logic [63:0] base,
                                          input logic [23:0] ext);
    logic [7:0] c;
    for (int i = 0; i < NAME_LEN; i++) begin
      c = path[8*i +: 8];
      if (c == base[8*i +: 8]) begin
        continue;
      end
      if (!is_separator(c) && c != CH_DOT) begin
        return 0;
      end
      for (int j = i; j < NAME_LEN; j++) begin
        if (base[8*j +: 8] != CH_SPACE) begin
          return 0;
        end
      end
      if (c == CH_DOT) begin
        return ext_bytes_used(path, ext, i + 1);
      end
      return ext_spaces_from(ext, 0) ? i + 1 : 0;
    end
    c = path[8*NAME_LEN +: 8];
    if (is_separator(c)) begin
      return ext_spaces_from(ext, 0) ? NAME_LEN + 1 : 0;
    end
    if (c == CH_DOT) begin
      return ext_bytes_used(path, ext, NAME_LEN + 1);
    end
    return 0;
  endfunction

  function automatic logic [103:0] text_bytes(input string s);
    logic [103:0] r;
    r = '0;
    for (int i = 0; i < s.len() && i < 13; i++) begin
      r[8*i +: 8] = s[i];
    end
    return r;
  endfunction

  function automatic logic [63:0] entry_base(input string s);
    logic [63:0] r;
    r = {NAME_LEN{CH_SPACE}};
    for (int i = 0; i < s.len() && i < NAME_LEN; i++) begin
      r[8*i +: 8] = s[i];
    end
    return r;
  endfunction

  function automatic logic [23:0] entry_ext(input string s);
    logic [23:0] r;
    r = {EXTN_LEN{CH_SPACE}};
    for (int i = 0; i < s.len() && i < EXTN_LEN; i++) begin
      r[8*i +: 8] = s[i];
    end
    return r;
  endfunction

  function automatic logic [7:0] filename_char();
    logic [7:0] c;
    int         n;
    if ($urandom_range(0, 7) == 0) begin
      do begin
        c = 8'($urandom_range(8'h21, 8'h7E));
      end while (c == CH_DOT || c == CH_SLASH || c == CH_BSLASH);
    end else begin
      n = $urandom_range(0, 35);
      c = (n < 26) ? 8'(8'h41 + n) : 8'(8'h30 + n - 26);
    end
    return c;
  endfunction

  function automatic logic [7:0] random_separator();
    case ($urandom_range(0, 2))
      0: return CH_NUL;
      1: return CH_SLASH;
      default: return CH_BSLASH;
    endcase
  endfunction

  task automatic offer_entry(input logic [103:0] path, input logic [63:0] base,
                             input logic [23:0] ext);
    int       gap;
    int       used;
    compare_t item;
    gap = tx_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    path_head <= path[63:0];
    path_tail <= path[103:64];
    name_base <= base;
    name_ext  <= ext;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    used      = entry_bytes_used(path, base, ext);
    item.path = path;
    item.base = base;
    item.ext  = ext;
    item.hit  = (used != 0);
    item.used = 4'(used);
    pending.push_back(item);
    words_sent++;
  endtask

  task automatic random_entry(output logic [103:0] path, output logic [63:0] base,
                              output logic [23:0] ext);
    int           blen;
    int           elen;
    int           pos;
    int           at;
    logic [7:0]   c;
    logic [127:0] junk;
    junk = {$urandom(), $urandom(), $urandom(), $urandom()};
    path = junk[103:0];
    base = {NAME_LEN{CH_SPACE}};
    ext  = {EXTN_LEN{CH_SPACE}};
    blen = $urandom_range(1, NAME_LEN);
    elen = $urandom_range(0, EXTN_LEN);
    for (pos = 0; pos < blen; pos++) begin
      c = filename_char();
      base[8*pos +: 8] = c;
      path[8*pos +: 8] = c;
    end
    if (elen > 0 || $urandom_range(0, 5) == 0) begin
      path[8*pos +: 8] = CH_DOT;
      pos++;
      for (int k = 0; k < elen; k++) begin
        c = filename_char();
        ext[8*k +: 8] = c;
        path[8*pos +: 8] = c;
        pos++;
      end
    end
    path[8*pos +: 8] = random_separator();
    case ($urandom_range(0, 15))
      7: begin
        at = $urandom_range(0, pos);
        path[8*at +: 8] = 8'($urandom);
      end
      8: begin
        at = $urandom_range(0, NAME_LEN - 1);
        base[8*at +: 8] = 8'($urandom);
      end
      9: begin
        at = $urandom_range(0, EXTN_LEN - 1);
        ext[8*at +: 8] = 8'($urandom);
      end
      10: begin
        at = $urandom_range(0, pos);
        path[8*at +: 8] = random_separator();
      end
      11: begin
        at = $urandom_range(0, blen - 1);
        case ($urandom_range(0, 4))
          0: c = CH_NUL;
          1: c = CH_SLASH;
          2: c = CH_BSLASH;
          3: c = CH_DOT;
          default: c = CH_SPACE;
        endcase
        base[8*at +: 8] = c;
        path[8*at +: 8] = c;
      end
      12: path[8*pos +: 8] = filename_char();
      13: begin
        junk = {$urandom(), $urandom(), $urandom(), $urandom()};
        path = junk[103:0];
        base = {$urandom(), $urandom()};
        ext  = 24'($urandom);
      end
      14: begin
        junk = {$urandom(), $urandom(), $urandom(), $urandom()};
        path = junk[103:0];
      end
      15: begin
        if (elen < EXTN_LEN) begin
          ext[8*elen +: 8] = filename_char();
        end
      end
      default: ;
    endcase
  endtask

  task automatic test_directed_cases();
    offer_entry(text_bytes("FILE.TXT/"), entry_base("FILE"), entry_ext("TXT"));
    offer_entry(text_bytes("FILE.TXT"), entry_base("FILE"), entry_ext("TXT"));
    offer_entry(text_bytes("FILE.TXT\\"), entry_base("FILE"), entry_ext("TXT"));
    offer_entry(text_bytes("FILE/"), entry_base("FILE"), entry_ext(""));
    offer_entry(text_bytes("FILE/"), entry_base("FILE"), entry_ext("TXT"));
    offer_entry(text_bytes("FILF.TXT"), entry_base("FILE"), entry_ext("TXT"));
    offer_entry(text_bytes("ABCDEFGH.TXT"), entry_base("ABCDEFGH"), entry_ext("TXT"));
    offer_entry(text_bytes("ABCDEFGH.TXTQ"), entry_base("ABCDEFGH"), entry_ext("TXT"));
    offer_entry(text_bytes("ABCDEFGH/"), entry_base("ABCDEFGH"), entry_ext(""));
    offer_entry(text_bytes("ABCDEFGHI"), entry_base("ABCDEFGH"), entry_ext(""));
    offer_entry(text_bytes("ABCDEFGH/"), entry_base("ABCDEFGH"), entry_ext("TXT"));
    offer_entry(text_bytes("ABCDEFGH.T/"), entry_base("ABCDEFGH"), entry_ext("T"));
    offer_entry(text_bytes("A.TXTX"), entry_base("A"), entry_ext("TXT"));
    offer_entry(text_bytes("A.TX/"), entry_base("A"), entry_ext("TX"));
    offer_entry(text_bytes("A.TX/"), entry_base("A"), entry_ext("TXT"));
    offer_entry(text_bytes("ABC."), entry_base("ABC"), entry_ext(""));
    offer_entry(text_bytes("/"), entry_base(""), entry_ext(""));
    offer_entry(text_bytes(""), entry_base(""), entry_ext(""));
    offer_entry(text_bytes("./"), entry_base(""), entry_ext(""));
    offer_entry(text_bytes("A/B/"), entry_base("A/B"), entry_ext(""));
    offer_entry(text_bytes("A.B."), entry_base("A.B"), entry_ext(""));
    offer_entry('0, '0, {EXTN_LEN{CH_SPACE}});
    offer_entry('0, '0, '0);
    offer_entry('1, '1, '1);
    directed_words = words_sent;
  endtask

  task automatic test_random_traffic(input int count);
    logic [103:0] path;
    logic [63:0]  base;
    logic [23:0]  ext;
    for (int n = 0; n < count; n++) begin
      random_entry(path, base, ext);
      offer_entry(path, base, ext);
    end
  endtask

  task automatic test_back_to_back(input int count);
    tx_idle = 1'b0;
    rx_idle <= 1'b0;
    test_random_traffic(count);
    tx_idle = 1'b1;
    rx_idle <= 1'b1;
  endtask

  task automatic test_output_stall(input int count);
    hold_requests <= hold_requests + 1;
    tx_idle = 1'b0;
    test_random_traffic(count);
    tx_idle = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait   <= 0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      rx_wait     <= HOLD_CYCLES;
      out_ready   <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait   <= rx_wait - 1;
      out_ready <= (rx_wait == 1);
    end else if (!out_ready) begin
      out_ready <= 1'b1;
    end else if (out_valid) begin
      rx_stall = rx_idle ? $urandom_range(0, 10) : 0;
      if (rx_stall > 0) begin
        out_ready <= 1'b0;
        rx_wait   <= rx_stall;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("Unexpected word: match %0b used %0d", is_match, bytes_used);
        end
      end else begin
        want = pending.pop_front();
        results_checked++;
        if (is_match) begin
          matches_seen++;
        end
        if (is_match !== want.hit || bytes_used !== want.used) begin
          errors++;
          if (errors <= 10) begin
            $display("Mismatch: path %h base %h ext %h: expected match %0b used %0d, got %0b %0d",
                     want.path, want.base, want.ext, want.hit, want.used, is_match,
                     bytes_used);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d words outstanding.", cycles,
               pending.size());
      $display("short_name_path_compare regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_traffic(1300);
    test_back_to_back(300);
    test_output_stall(120);
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Sent %0d words (%0d directed, the rest random with and without idling).",
             words_sent, directed_words);
    $display("Checked %0d results, %0d of them matches; %0d errors.", results_checked,
             matches_seen, errors);
    if (errors == 0) begin
      $display("short_name_path_compare regression: pass");
    end else begin
      $display("short_name_path_compare regression: fail");
    end
    $finish;
  end

endmodule
